// File: sv/wsq_pkg.sv
// ----------------------------------------------------------------------------
// wsq_pkg
// Shared types, constants and helpers for the rigid-body site generator.
// ----------------------------------------------------------------------------
package wsq_pkg;

	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int QUAT_FRAC_BITS_DEF  = 30;

	localparam int SITES_PER_WATER = 4;
	localparam int CNT_W           = $clog2(SITES_PER_WATER);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SITES_PER_WATER - 1);

	localparam int SAT_IN_W = 80;

	typedef logic signed [31:0] word_t;
	typedef word_t [2:0][2:0] mat_t;

	typedef enum logic {
		BODY_WATER = 1'b0,
		BODY_HEAD  = 1'b1
	} body_kind_t;

	typedef enum logic [1:0] {
		SITE_CENTRE   = 2'd0,
		SITE_OXYGEN   = 2'd1,
		SITE_HYDROGEN = 2'd2,
		SITE_HEAD     = 2'd3
	} site_kind_t;

	typedef enum logic {
		REG_EMIT_WATER  = 1'b0,
		REG_EMIT_DIPOLE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} rot_ctl_t;

	function automatic word_t sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SAT_IN_W-1:0] max_v;
		logic signed [SAT_IN_W-1:0] min_v;
		max_v = SAT_IN_W'(64'sd2147483647);
		min_v = SAT_IN_W'(-64'sd2147483648);
		if (v > max_v) begin
			return 32'sh7fffffff;
		end else if (v < min_v) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// File: sv/wsq_rotmat.sv
// ----------------------------------------------------------------------------
// wsq_rotmat
// Quaternion to rotation matrix: registered products, then saturated sums.
// ----------------------------------------------------------------------------
module wsq_rotmat import wsq_pkg::*; #(
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  rot_ctl_t           ctl,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output mat_t               a_s2
);

	localparam int PW = 64 - QUAT_FRAC_BITS;
	localparam int SW = PW + 3;

	logic signed [63:0] m00, m11, m22, m33, m01, m02, m03, m12, m13, m23;
	logic signed [PW-1:0] p00_s1, p11_s1, p22_s1, p33_s1, p01_s1;
	logic signed [PW-1:0] p02_s1, p03_s1, p12_s1, p13_s1, p23_s1;
	logic signed [SW-1:0] e00, e11, e22, e33, e01, e02, e03, e12, e13, e23;
	mat_t a_d;

	always_comb begin
		m00 = quat_w * quat_w;
		m11 = quat_x * quat_x;
		m22 = quat_y * quat_y;
		m33 = quat_z * quat_z;
		m01 = quat_w * quat_x;
		m02 = quat_w * quat_y;
		m03 = quat_w * quat_z;
		m12 = quat_x * quat_y;
		m13 = quat_x * quat_z;
		m23 = quat_y * quat_z;
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			p00_s1 <= m00[63:QUAT_FRAC_BITS];
			p11_s1 <= m11[63:QUAT_FRAC_BITS];
			p22_s1 <= m22[63:QUAT_FRAC_BITS];
			p33_s1 <= m33[63:QUAT_FRAC_BITS];
			p01_s1 <= m01[63:QUAT_FRAC_BITS];
			p02_s1 <= m02[63:QUAT_FRAC_BITS];
			p03_s1 <= m03[63:QUAT_FRAC_BITS];
			p12_s1 <= m12[63:QUAT_FRAC_BITS];
			p13_s1 <= m13[63:QUAT_FRAC_BITS];
			p23_s1 <= m23[63:QUAT_FRAC_BITS];
		end
	end

	always_comb begin
		e00 = SW'(p00_s1);
		e11 = SW'(p11_s1);
		e22 = SW'(p22_s1);
		e33 = SW'(p33_s1);
		e01 = SW'(p01_s1);
		e02 = SW'(p02_s1);
		e03 = SW'(p03_s1);
		e12 = SW'(p12_s1);
		e13 = SW'(p13_s1);
		e23 = SW'(p23_s1);
		a_d[0][0] = sat32(SAT_IN_W'(e00 + e11 - e22 - e33));
		a_d[0][1] = sat32(SAT_IN_W'((e12 + e03) <<< 1));
		a_d[0][2] = sat32(SAT_IN_W'((e13 - e02) <<< 1));
		a_d[1][0] = sat32(SAT_IN_W'((e12 - e03) <<< 1));
		a_d[1][1] = sat32(SAT_IN_W'(e00 - e11 + e22 - e33));
		a_d[1][2] = sat32(SAT_IN_W'((e23 + e01) <<< 1));
		a_d[2][0] = sat32(SAT_IN_W'((e13 + e02) <<< 1));
		a_d[2][1] = sat32(SAT_IN_W'((e23 - e01) <<< 1));
		a_d[2][2] = sat32(SAT_IN_W'(e00 - e11 - e22 + e33));
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			a_s2 <= a_d;
		end
	end

endmodule

// File: sv/water_sites_from_quaternion.sv
// ----------------------------------------------------------------------------
// water_sites_from_quaternion
// Rigid-body site generator: rotation matrix from a quaternion, dipole
// direction and water centre, oxygen and hydrogen sites at rotated offsets.
// ----------------------------------------------------------------------------
//  channel   handshake              carries
//  input     in_valid / in_ready    body_kind, pos_*, quat_*
//  output    out_valid / out_ready  site_kind, site_*, dir_*, dipole_valid, last
//  config    APB psel/penable       emit_water (0x0), emit_dipole (0x4)
//
//  Four register stages: quaternion products, matrix sums, offset products,
//  site sums into the output buffer, from which the first site is offered.
//  A head body gives a single site, a dropped water body none. A water body
//  with sites on gives four; the single output buffer holds it to the last.
//  Empty stages collapse under a stall; nothing is lost or repeated.
//  arst_n clears valid bits, the site counter and both registers.
// ----------------------------------------------------------------------------
module water_sites_from_quaternion import wsq_pkg::*; #(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
	parameter int QUAT_FRAC_BITS  = QUAT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               body_kind,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         site_kind,
	output logic signed [31:0] site_x,
	output logic signed [31:0] site_y,
	output logic signed [31:0] site_z,
	output logic signed [31:0] dir_x,
	output logic signed [31:0] dir_y,
	output logic signed [31:0] dir_z,
	output logic               dipole_valid,
	output logic               last
);

	localparam longint MAG_O = ((longint'(6540) << COORD_FRAC_BITS) + 50000) / 100000;
	localparam longint MAG_H = ((longint'(75695) << COORD_FRAC_BITS) + 50000) / 100000;
	localparam longint MAG_Z = ((longint'(52060) << COORD_FRAC_BITS) + 50000) / 100000;
	localparam int OFF_W = COORD_FRAC_BITS + 1;
	localparam int TW    = 32 + OFF_W;
	localparam int TW1   = TW + 1;
	localparam int RW    = (TW + 2 - QUAT_FRAC_BITS > 34) ? TW + 2 - QUAT_FRAC_BITS : 34;
	localparam logic signed [OFF_W-1:0] OFF_O = OFF_W'(-MAG_O);
	localparam logic signed [OFF_W-1:0] OFF_H = OFF_W'(MAG_H);
	localparam logic signed [OFF_W-1:0] OFF_Z = OFF_W'(MAG_Z);

	logic emit_water_q, emit_dipole_q;
	logic wr_en;
	reg_idx_t wr_idx;

	logic en1, en2, en3, free4, take, last_site;
	rot_ctl_t rot_ctl;

	logic v_s1, v_s2, v_s3, v_s4;
	body_kind_t kind_s1, kind_s2, kind_s3, kind_s4;
	word_t pos_in [3];
	word_t pos_s1 [3];
	word_t pos_s2 [3];
	word_t pos_s3 [3];
	word_t pos_s4 [3];
	mat_t a_s2;

	logic signed [TW-1:0] t_o_s3 [3];
	logic signed [TW-1:0] t_h_s3 [3];
	logic signed [TW-1:0] t_z_s3 [3];
	word_t dir_s3 [3];
	word_t dir_s4 [3];

	logic signed [TW1-1:0] acc_o [3];
	logic signed [TW1-1:0] acc_h1 [3];
	logic signed [TW1-1:0] acc_h2 [3];
	word_t oxy_d [3];
	word_t h1_d [3];
	word_t h2_d [3];
	word_t oxy_s4 [3];
	word_t h1_s4 [3];
	word_t h2_s4 [3];

	logic [CNT_W-1:0] cnt_q;
	word_t sel_site [3];
	word_t sel_dir [3];
	logic carries_dir;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_water_q  <= 1'b0;
			emit_dipole_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_EMIT_WATER:  emit_water_q  <= pwdata[0];
				REG_EMIT_DIPOLE: emit_dipole_q <= pwdata[0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			REG_EMIT_WATER:  prdata = {31'd0, emit_water_q};
			REG_EMIT_DIPOLE: prdata = {31'd0, emit_dipole_q};
			default:         prdata = '0;
		endcase
	end

	// pipeline control
	assign take      = v_s4 & out_ready;
	assign last_site = (kind_s4 == BODY_HEAD) || (cnt_q == CNT_LAST);
	assign free4     = !v_s4 || (take && last_site);
	assign en3       = free4 || !v_s3;
	assign en2       = en3 || !v_s2;
	assign en1       = en2 || !v_s1;
	assign in_ready  = en1;
	assign rot_ctl   = '{ld_s1: en1, ld_s2: en2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (free4) begin
				// drop water bodies while site output is off
				v_s4 <= v_s3 && (kind_s3 == BODY_HEAD || emit_water_q);
			end
			if (take) begin
				cnt_q <= last_site ? '0 : cnt_q + 1'b1;
			end
		end
	end

	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;

	wsq_rotmat #(
		.QUAT_FRAC_BITS(QUAT_FRAC_BITS)
	) u_rotmat (
		.clk    (clk),
		.ctl    (rot_ctl),
		.quat_w (quat_w),
		.quat_x (quat_x),
		.quat_y (quat_y),
		.quat_z (quat_z),
		.a_s2   (a_s2)
	);

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1 <= body_kind_t'(body_kind);
			pos_s1  <= pos_in;
		end
		if (en2) begin
			kind_s2 <= kind_s1;
			pos_s2  <= pos_s1;
		end
	end

	// stage 3: rotated offset products
	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3 <= kind_s2;
			pos_s3  <= pos_s2;
			for (int i = 0; i < 3; i++) begin
				t_o_s3[i] <= $signed(a_s2[2][i]) * OFF_O;
				t_h_s3[i] <= $signed(a_s2[1][i]) * OFF_H;
				t_z_s3[i] <= $signed(a_s2[2][i]) * OFF_Z;
				dir_s3[i] <= a_s2[2][i];
			end
		end
	end

	// stage 4: site sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_o[i]  = TW1'(t_o_s3[i]);
			acc_h1[i] = TW1'(t_z_s3[i]) - TW1'(t_h_s3[i]);
			acc_h2[i] = TW1'(t_z_s3[i]) + TW1'(t_h_s3[i]);
			oxy_d[i]  = sat32(SAT_IN_W'(RW'(pos_s3[i]) + RW'(acc_o[i] >>> QUAT_FRAC_BITS)));
			h1_d[i]   = sat32(SAT_IN_W'(RW'(pos_s3[i]) + RW'(acc_h1[i] >>> QUAT_FRAC_BITS)));
			h2_d[i]   = sat32(SAT_IN_W'(RW'(pos_s3[i]) + RW'(acc_h2[i] >>> QUAT_FRAC_BITS)));
		end
	end

	always_ff @(posedge clk) begin
		if (free4) begin
			kind_s4 <= kind_s3;
			pos_s4  <= pos_s3;
			dir_s4  <= dir_s3;
			oxy_s4  <= oxy_d;
			h1_s4   <= h1_d;
			h2_s4   <= h2_d;
		end
	end

	// output select
	assign carries_dir = (kind_s4 == BODY_HEAD) || (cnt_q == '0);

	always_comb begin
		site_kind = SITE_HEAD;
		sel_site  = pos_s4;
		if (kind_s4 == BODY_WATER) begin
			case (cnt_q)
				2'd0: begin
					site_kind = SITE_CENTRE;
					sel_site  = pos_s4;
				end
				2'd1: begin
					site_kind = SITE_OXYGEN;
					sel_site  = oxy_s4;
				end
				2'd2: begin
					site_kind = SITE_HYDROGEN;
					sel_site  = h1_s4;
				end
				default: begin
					site_kind = SITE_HYDROGEN;
					sel_site  = h2_s4;
				end
			endcase
		end
		for (int i = 0; i < 3; i++) begin
			sel_dir[i] = carries_dir ? dir_s4[i] : '0;
		end
	end

	assign out_valid    = v_s4;
	assign site_x       = sel_site[0];
	assign site_y       = sel_site[1];
	assign site_z       = sel_site[2];
	assign dir_x        = sel_dir[0];
	assign dir_y        = sel_dir[1];
	assign dir_z        = sel_dir[2];
	assign dipole_valid = carries_dir & emit_dipole_q;
	assign last         = last_site;

	a_cnt_water: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> v_s4 && kind_s4 == BODY_WATER)
		else $error("site counter running without a water item");

	a_water_continues: assert property (@(posedge clk) disable iff (!arst_n)
		take && !last_site |=> out_valid && cnt_q == $past(cnt_q) + 1'b1)
		else $error("water item lost sites");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ready)
		else $error("input stalled with empty output buffer");

	a_head_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && site_kind == SITE_HEAD |-> last)
		else $error("head item not closed by last");

	a_dipole_site: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dipole_valid |-> site_kind == SITE_CENTRE || site_kind == SITE_HEAD)
		else $error("dipole flag on an atom site");

endmodule

// File: test/tb_water_sites_from_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_water_sites_from_quaternion
// Self-checking bench for the rigid-body site generator. Bodies are fed
// from a queue, and every accepted body is run through a fixed-point
// forecast of its sites. Each site that leaves the block is compared field
// by field with the oldest site in the forecast queue. The bench steps
// through several register settings, writing them while the block is idle.
// Both channels stall at random outside the calm phase.
// ----------------------------------------------------------------------------
module tb_water_sites_from_quaternion;
	import wsq_pkg::*;

	localparam int     QUAT_FB     = QUAT_FRAC_BITS_DEF;
	localparam word_t  ONE_Q       = 32'sh40000000;
	localparam word_t  HALF_ROOT2  = 32'sd759250125;
	localparam longint OXY_Z       = -4286;
	localparam longint HYD_Y       = 49607;
	localparam longint HYD_Z       = 34118;
	localparam int     STALL_LIMIT = 1000;
	localparam int     SETTLE      = 12;

	typedef struct packed {
		body_kind_t    kind;
		word_t [2:0]   pos;
		word_t [3:0]   quat;
	} body_t;

	typedef struct packed {
		site_kind_t    kind;
		word_t [2:0]   xyz;
		word_t [2:0]   dir;
		logic          dv;
		logic          fin;
	} site_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               body_kind = 1'b0;
	logic signed [31:0] pos_x = '0;
	logic signed [31:0] pos_y = '0;
	logic signed [31:0] pos_z = '0;
	logic signed [31:0] quat_w = '0;
	logic signed [31:0] quat_x = '0;
	logic signed [31:0] quat_y = '0;
	logic signed [31:0] quat_z = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         site_kind;
	logic signed [31:0] site_x;
	logic signed [31:0] site_y;
	logic signed [31:0] site_z;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;
	logic               dipole_valid;
	logic               last;

	body_t bodies_waiting[$];
	site_t sites_due[$];
	body_t offered;
	bit    water_on = 1'b0;
	bit    dipole_on = 1'b0;
	bit    calm = 1'b0;
	bit    failed = 1'b0;
	int    stall_cycles = 0;

	water_sites_from_quaternion dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .body_kind(body_kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
		.out_valid(out_valid), .out_ready(out_ready), .site_kind(site_kind),
		.site_x(site_x), .site_y(site_y), .site_z(site_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.dipole_valid(dipole_valid), .last(last)
	);

	always #10 clk = ~clk;

	function automatic word_t clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic void forecast_sites(input body_t b);
		longint q[4];
		longint p[4][4];
		longint r[3][3];
		longint acc;
		longint oy;
		longint oz;
		site_t  s;
		for (int i = 0; i < 4; i++) q[i] = $signed(b.quat[i]);
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				p[i][j] = (q[i] * q[j]) >>> QUAT_FB;
		r[0][0] = p[0][0] + p[1][1] - p[2][2] - p[3][3];
		r[0][1] = 2 * (p[1][2] + p[0][3]);
		r[0][2] = 2 * (p[1][3] - p[0][2]);
		r[1][0] = 2 * (p[1][2] - p[0][3]);
		r[1][1] = p[0][0] - p[1][1] + p[2][2] - p[3][3];
		r[1][2] = 2 * (p[2][3] + p[0][1]);
		r[2][0] = 2 * (p[1][3] + p[0][2]);
		r[2][1] = 2 * (p[2][3] - p[0][1]);
		r[2][2] = p[0][0] - p[1][1] - p[2][2] + p[3][3];
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = clamp32(r[i][j]);

		s.xyz = b.pos;
		for (int i = 0; i < 3; i++) s.dir[i] = r[2][i][31:0];
		s.dv = dipole_on;
		if (b.kind == BODY_HEAD) begin
			s.kind = SITE_HEAD;
			s.fin = 1'b1;
			sites_due.push_back(s);
			return;
		end
		if (!water_on) return;
		s.kind = SITE_CENTRE;
		s.fin = 1'b0;
		sites_due.push_back(s);

		// oxygen, then the two hydrogens; body x offset is zero for all three
		for (int k = 0; k < 3; k++) begin
			oy = (k == 0) ? 0 : ((k == 1) ? -HYD_Y : HYD_Y);
			oz = (k == 0) ? OXY_Z : HYD_Z;
			for (int i = 0; i < 3; i++) begin
				acc = r[1][i] * oy + r[2][i] * oz;
				s.xyz[i] = clamp32(longint'($signed(b.pos[i])) + (acc >>> QUAT_FB));
			end
			s.kind = (k == 0) ? SITE_OXYGEN : SITE_HYDROGEN;
			s.dir = '0;
			s.dv = 1'b0;
			s.fin = (k == 2);
			sites_due.push_back(s);
		end
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
			failed = 1'b1;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) forecast_sites(offered);
			if (!in_valid || in_ready) begin
				if (bodies_waiting.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
					offered = bodies_waiting.pop_front();
					body_kind <= offered.kind;
					pos_x <= offered.pos[0];
					pos_y <= offered.pos[1];
					pos_z <= offered.pos[2];
					quat_w <= offered.quat[0];
					quat_x <= offered.quat[1];
					quat_y <= offered.quat[2];
					quat_z <= offered.quat[3];
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		site_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (sites_due.size() == 0) begin
					$error("site with none expected: kind %0d x %0d y %0d z %0d",
						site_kind, site_x, site_y, site_z);
					failed = 1'b1;
				end else begin
					e = sites_due.pop_front();
					check_field("site_kind", e.kind, site_kind);
					check_field("site_x", e.xyz[0], site_x);
					check_field("site_y", e.xyz[1], site_y);
					check_field("site_z", e.xyz[2], site_z);
					check_field("dir_x", e.dir[0], dir_x);
					check_field("dir_y", e.dir[1], dir_y);
					check_field("dir_z", e.dir[2], dir_z);
					check_field("dipole_valid", e.dv, dipole_valid);
					check_field("last", e.fin, last);
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 13);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input bit val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom & ~32'd1) | {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_EMIT_WATER) water_on = val;
		else dipole_on = val;
	endtask

	task automatic apply_settings(input bit ew, input bit ed);
		reg_write(REG_EMIT_WATER, ew);
		reg_write(REG_EMIT_DIPOLE, ed);
	endtask

	function automatic void queue_body(input body_kind_t k, input word_t px, input word_t py,
			input word_t pz, input word_t qw, input word_t qx, input word_t qy,
			input word_t qz);
		body_t b;
		b.kind = k;
		b.pos[0] = px;
		b.pos[1] = py;
		b.pos[2] = pz;
		b.quat[0] = qw;
		b.quat[1] = qx;
		b.quat[2] = qy;
		b.quat[3] = qz;
		bodies_waiting.push_back(b);
	endfunction

	function automatic word_t rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff - $urandom_range(0, 65535);
			1: return 32'sh80000000 + $urandom_range(0, 65535);
			2, 3: return $signed($urandom) >>> $urandom_range(8, 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic word_t rand_quat();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return ONE_Q;
					3: return -ONE_Q;
					default: return '0;
				endcase
			end
			1, 2: return $urandom;
			default: return $signed($urandom) >>> $urandom_range(1, 3);
		endcase
	endfunction

	function automatic void queue_random(input int n);
		repeat (n) queue_body(body_kind_t'($urandom_range(0, 1)), rand_coord(), rand_coord(),
			rand_coord(), rand_quat(), rand_quat(), rand_quat(), rand_quat());
	endfunction

	function automatic void queue_directed();
		body_kind_t bk;
		for (int k = 0; k < 2; k++) begin
			bk = body_kind_t'(k);
			queue_body(bk, 0, 0, 0, ONE_Q, 0, 0, 0);
			queue_body(bk, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, ONE_Q, 0, 0, 0);
			queue_body(bk, 32'sh80000000, 32'sh80000000, 32'sh80000000, ONE_Q, 0, 0, 0);
			queue_body(bk, 32'sh80000000, 32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7fffffff,
				32'sh7fffffff, 32'sh7fffffff);
			queue_body(bk, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000,
				32'sh80000000);
			queue_body(bk, 32'sh00018000, -32'sh00020000, 32'sh00004000, 0, ONE_Q, 0, 0);
			queue_body(bk, -1, -1, -1, -1, -1, 1, -1);
			queue_body(bk, 32'sh12345678, 32'shedcba988, 32'sh7ffff000, HALF_ROOT2, 0,
				HALF_ROOT2, 0);
		end
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (bodies_waiting.size() != 0 || in_valid || sites_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		queue_random(30);
		wait_drained();

		apply_settings(1'b1, 1'b1);
		queue_directed();
		queue_random(45);
		wait_drained();

		apply_settings(1'b1, 1'b0);
		calm = 1'b1;
		queue_random(45);
		wait_drained();
		calm = 1'b0;

		apply_settings(1'b0, 1'b1);
		queue_random(40);
		wait_drained();

		apply_settings(1'b1, 1'b1);
		queue_random(50);
		wait_drained();

		if (!failed && sites_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: files.f
sv/wsq_pkg.sv
sv/wsq_rotmat.sv
sv/water_sites_from_quaternion.sv
test/tb_water_sites_from_quaternion.sv
